[rtl/page_frame_free_list_allocator_assert.svh]
// Assertion macros used by the page frame allocator datapath.
`ifndef PAGE_FRAME_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define PAGE_FRAME_FREE_LIST_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PFA_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfa assertion failed (same cycle)");

// Next-cycle implication, disabled while reset is asserted.
`define PFA_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pfa assertion failed (next cycle)");

`endif

[rtl/pfa_pkg.sv]
// Shared types and constants of the page frame allocator.
`default_nettype none

package pfa_pkg;

    // Field widths fixed by the interface.
    localparam int KIND_W   = 3;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;
    localparam int FCOUNT_W = 11;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_MARK  = 2'd2;

    // Page kind tags.
    localparam logic [KIND_W-1:0] KIND_UNUSED    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ALLOCATED = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FREE      = 3'd4;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK            = 3'd0,
        ST_NO_PAGE       = 3'd1,
        ST_MISALIGNED    = 3'd2,
        ST_NOT_ALLOCATED = 3'd3,
        ST_BAD_RANGE     = 3'd4
    } t_status;

    // Controller states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC,
        S_FREE,
        S_MCHK,
        S_SCAN,
        S_MARK,
        S_NOP
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    clr_wr;   // write unused tag at the walk index
        logic    load;     // capture the input item
        logic    step;     // advance the walk index
        logic    rewind;   // walk index back to the first range page
        logic    pop;      // take the head page off the free list
        logic    append;   // append the walk page to the free list
        logic    mark_wr;  // tag the walk page with the item's kind
        logic    respond;  // present a result next cycle
        t_status status;   // status of that result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;          // clearing pass is at its last page
        logic nonempty;          // free list holds a page
        logic addr_misaligned;   // latched address has low bits set
        logic free_out_of_range; // latched address is not a managed page
        logic kind_is_alloc;     // tag read back is allocated
        logic kind_is_free;      // tag read back is free
        logic mark_misaligned;   // range start or end has low bits set
        logic mark_bad_range;    // range is empty, reversed or unmanaged
        logic at_last;           // walk index is at the last range page
    } t_stat;

endpackage

`default_nettype wire

[rtl/page_frame_free_list_allocator.sv]
// Top level of the page frame allocator: controller plus datapath.
`default_nettype none

// Page frame allocator with a first-in first-out free list. Pulse start while busy is
// low to issue an item; its result shows on the o_ ports for exactly one cycle with
// o_done high, and the receiver cannot stall it. After reset the tag store is cleared
// one page per cycle, and busy stays high until every page is cleared. Alloc, free and
// an unknown op go from idle to their own state and back; free tests the registered
// read of the tag store, and alloc takes the next head from the registered read of the
// link store. A range mark checks the range, scans it reading one tag per cycle, stops
// early if a tag is free, then tags each page writing one page per cycle. The result
// strobe comes the cycle after the last working cycle, with busy already low.
// base_address may be written at any time through the cfg channel, which is always
// ready; write it only while no item is in progress.
module page_frame_free_list_allocator #(
    parameter int NUM_PAGES  = 1024,
    parameter int PAGE_SHIFT = 12
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_op,
    input  wire logic [31:0] i_page_address,
    input  wire logic [31:0] i_range_end,
    input  wire logic [2:0]  i_kind,
    output logic             o_done,
    output logic [2:0]       o_status,
    output logic [31:0]      o_result_address,
    output logic [10:0]      o_free_count,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_cfg_data
);

    pfa_pkg::t_cmd  cmd;
    pfa_pkg::t_stat stat;

    assign o_cfg_ready = 1'b1;

    // Sequencing of each item.
    pfa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (i_op),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // Stores, list pointers and address checks.
    pfa_datapath #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_data       (i_cfg_data),
        .i_page_address   (i_page_address),
        .i_range_end      (i_range_end),
        .i_kind           (i_kind),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_result_address (o_result_address),
        .o_free_count     (o_free_count)
    );

endmodule

`default_nettype wire

[rtl/pfa_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module pfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/pfa_ctrl.sv]
// Controller state machine of the page frame allocator.
`default_nettype none

module pfa_ctrl (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [pfa_pkg::OP_W-1:0]   i_op,
    input  wire pfa_pkg::t_stat             i_stat,
    output pfa_pkg::t_cmd                   o_cmd,
    output logic                            o_busy
);

    pfa_pkg::t_state r_state;
    pfa_pkg::t_state n_state;
    logic            accept;

    assign accept = i_start && !o_busy;

    // State register; reset starts the clearing pass of the tag store.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfa_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            pfa_pkg::S_CLEAR: begin
                if (i_stat.clr_last) begin
                    n_state = pfa_pkg::S_IDLE;
                end
            end
            pfa_pkg::S_IDLE: begin
                if (accept) begin
                    case (i_op)
                        pfa_pkg::OP_ALLOC: n_state = pfa_pkg::S_ALLOC;
                        pfa_pkg::OP_FREE:  n_state = pfa_pkg::S_FREE;
                        pfa_pkg::OP_MARK:  n_state = pfa_pkg::S_MCHK;
                        default:           n_state = pfa_pkg::S_NOP;
                    endcase
                end
            end
            pfa_pkg::S_MCHK: begin
                if (i_stat.mark_misaligned || i_stat.mark_bad_range) begin
                    n_state = pfa_pkg::S_IDLE;
                end else begin
                    n_state = pfa_pkg::S_SCAN;
                end
            end
            pfa_pkg::S_SCAN: begin
                if (i_stat.kind_is_free) begin
                    n_state = pfa_pkg::S_IDLE;
                end else if (i_stat.at_last) begin
                    n_state = pfa_pkg::S_MARK;
                end
            end
            pfa_pkg::S_MARK: begin
                if (i_stat.at_last) begin
                    n_state = pfa_pkg::S_IDLE;
                end
            end
            pfa_pkg::S_ALLOC, pfa_pkg::S_FREE, pfa_pkg::S_NOP: begin
                n_state = pfa_pkg::S_IDLE;
            end
            default: begin
                n_state = pfa_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath commands.
    always_comb begin
        o_cmd        = '0;
        o_cmd.status = pfa_pkg::ST_OK;
        o_busy       = 1'b1;
        case (r_state)
            pfa_pkg::S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                o_cmd.step   = 1'b1;
            end
            pfa_pkg::S_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = accept;
            end
            pfa_pkg::S_ALLOC: begin
                o_cmd.respond = 1'b1;
                if (i_stat.nonempty) begin
                    o_cmd.pop = 1'b1;
                end else begin
                    o_cmd.status = pfa_pkg::ST_NO_PAGE;
                end
            end
            pfa_pkg::S_FREE: begin
                o_cmd.respond = 1'b1;
                if (i_stat.addr_misaligned) begin
                    o_cmd.status = pfa_pkg::ST_MISALIGNED;
                end else if (i_stat.free_out_of_range || !i_stat.kind_is_alloc) begin
                    o_cmd.status = pfa_pkg::ST_NOT_ALLOCATED;
                end else begin
                    o_cmd.append = 1'b1;
                end
            end
            pfa_pkg::S_MCHK: begin
                if (i_stat.mark_misaligned) begin
                    o_cmd.respond = 1'b1;
                    o_cmd.status  = pfa_pkg::ST_MISALIGNED;
                end else if (i_stat.mark_bad_range) begin
                    o_cmd.respond = 1'b1;
                    o_cmd.status  = pfa_pkg::ST_BAD_RANGE;
                end
            end
            pfa_pkg::S_SCAN: begin
                if (i_stat.kind_is_free) begin
                    o_cmd.respond = 1'b1;
                    o_cmd.status  = pfa_pkg::ST_BAD_RANGE;
                end else if (i_stat.at_last) begin
                    o_cmd.rewind = 1'b1;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            pfa_pkg::S_MARK: begin
                o_cmd.mark_wr = 1'b1;
                if (i_stat.at_last) begin
                    o_cmd.respond = 1'b1;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            pfa_pkg::S_NOP: begin
                o_cmd.respond = 1'b1;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/pfa_datapath.sv]
// Datapath of the page frame allocator: tag and link stores, list pointers, checks.
`default_nettype none

`include "page_frame_free_list_allocator_assert.svh"

module pfa_datapath #(
    parameter int NUM_PAGES  = 1024,
    parameter int PAGE_SHIFT = 12
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    input  wire logic [31:0]                      i_cfg_data,
    input  wire logic [31:0]                      i_page_address,
    input  wire logic [31:0]                      i_range_end,
    input  wire logic [pfa_pkg::KIND_W-1:0]       i_kind,
    input  wire pfa_pkg::t_cmd                    i_cmd,
    output pfa_pkg::t_stat                        o_stat,
    output logic                                  o_done,
    output logic [pfa_pkg::STATUS_W-1:0]          o_status,
    output logic [31:0]                           o_result_address,
    output logic [pfa_pkg::FCOUNT_W-1:0]          o_free_count
);

    localparam int          IW         = $clog2(NUM_PAGES);
    localparam int          CW         = $clog2(NUM_PAGES + 1);
    localparam logic [31:0] PAGE_BYTES = 32'd1 << PAGE_SHIFT;
    localparam logic [31:0] NPAGES32   = 32'(NUM_PAGES);

    // Configuration and latched item fields.
    logic [31:0]                r_base;
    logic [31:0]                r_page_address;
    logic [31:0]                r_range_end;
    logic [pfa_pkg::KIND_W-1:0] r_kind;

    // Walk index and range bounds.
    logic [IW-1:0] r_idx;
    logic [IW-1:0] n_idx;
    logic [IW-1:0] r_first;
    logic [IW-1:0] r_last;

    // Free list state.
    logic [IW-1:0] r_head;
    logic [IW-1:0] n_head;
    logic [IW-1:0] r_tail;
    logic [IW-1:0] n_tail;
    logic          r_nonempty;
    logic          n_nonempty;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    // Result registers.
    logic             r_done;
    pfa_pkg::t_status r_status;
    logic [31:0]      r_result;

    // Store ports.
    logic                       kind_we;
    logic [IW-1:0]              kind_waddr;
    logic [pfa_pkg::KIND_W-1:0] kind_wdata;
    logic [pfa_pkg::KIND_W-1:0] kind_rdata;
    logic                       link_we;
    logic [IW-1:0]              link_rdata;

    // Address arithmetic.
    logic [31:0]   off_in;
    logic [IW-1:0] idx_in;
    logic [31:0]   off_lat;
    logic [31:0]   end_off;
    logic [31:0]   last_off;
    logic          below_base;
    logic          do_append;
    logic [31:0]   head_address;

    assign off_in       = i_page_address - r_base;
    assign idx_in       = IW'(off_in >> PAGE_SHIFT);
    assign off_lat      = r_page_address - r_base;
    assign end_off      = r_range_end - r_base - 32'd1;
    assign last_off     = r_range_end - PAGE_BYTES - r_base;
    assign below_base   = r_page_address < r_base;
    assign head_address = r_base + (32'(r_head) << PAGE_SHIFT);

    // Status toward the controller.
    always_comb begin
        o_stat.clr_last          = r_idx == IW'(NUM_PAGES - 1);
        o_stat.nonempty          = r_nonempty;
        o_stat.addr_misaligned   = |r_page_address[PAGE_SHIFT-1:0];
        o_stat.free_out_of_range = below_base || ((off_lat >> PAGE_SHIFT) >= NPAGES32);
        o_stat.kind_is_alloc     = kind_rdata == pfa_pkg::KIND_ALLOCATED;
        o_stat.kind_is_free      = kind_rdata == pfa_pkg::KIND_FREE;
        o_stat.mark_misaligned   = (|r_page_address[PAGE_SHIFT-1:0])
                                 || (|r_range_end[PAGE_SHIFT-1:0]);
        o_stat.mark_bad_range    = (r_page_address >= r_range_end) || below_base
                                 || ((end_off >> PAGE_SHIFT) >= NPAGES32);
        o_stat.at_last           = r_idx == r_last;
    end

    // Walk index next value; it also addresses the tag read port.
    always_comb begin
        if (i_cmd.load) begin
            n_idx = idx_in;
        end else if (i_cmd.rewind) begin
            n_idx = r_first;
        end else if (i_cmd.step) begin
            n_idx = r_idx + 1'b1;
        end else begin
            n_idx = r_idx;
        end
    end

    // A mark with the free tag appends every page of the range.
    assign do_append = i_cmd.append || (i_cmd.mark_wr && (r_kind == pfa_pkg::KIND_FREE));

    // Tag store write selection.
    always_comb begin
        kind_we    = 1'b1;
        kind_waddr = r_idx;
        kind_wdata = r_kind;
        if (i_cmd.clr_wr) begin
            kind_wdata = pfa_pkg::KIND_UNUSED;
        end else if (i_cmd.pop) begin
            kind_waddr = r_head;
            kind_wdata = pfa_pkg::KIND_ALLOCATED;
        end else if (do_append) begin
            kind_wdata = pfa_pkg::KIND_FREE;
        end else if (!i_cmd.mark_wr) begin
            kind_we = 1'b0;
        end
    end

    // The old tail links to a new page only when the list already holds one.
    assign link_we = do_append && r_nonempty;

    // Free list pointer and count updates.
    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_nonempty = r_nonempty;
        n_count    = r_count;
        if (i_cmd.pop) begin
            n_count = r_count - 1'b1;
            if (r_head == r_tail) begin
                n_head     = '0;
                n_tail     = '0;
                n_nonempty = 1'b0;
            end else begin
                n_head = link_rdata;
            end
        end else if (do_append) begin
            if (!r_nonempty) begin
                n_head = r_idx;
            end
            n_tail     = r_idx;
            n_nonempty = 1'b1;
            n_count    = r_count + 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base     <= '0;
            r_idx      <= '0;
            r_head     <= '0;
            r_tail     <= '0;
            r_nonempty <= 1'b0;
            r_count    <= '0;
            r_done     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_base <= i_cfg_data;
            end
            r_idx      <= n_idx;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_nonempty <= n_nonempty;
            r_count    <= n_count;
            r_done     <= i_cmd.respond;
        end
    end

    // Item fields, range bounds and result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_page_address <= i_page_address;
            r_range_end    <= i_range_end;
            r_kind         <= i_kind;
            r_first        <= idx_in;
        end
        r_last <= IW'(last_off >> PAGE_SHIFT);
        if (i_cmd.respond) begin
            r_status <= i_cmd.status;
            r_result <= i_cmd.pop ? head_address : 32'd0;
        end
    end

    // Page kind tags.
    pfa_ram #(
        .WIDTH (pfa_pkg::KIND_W),
        .DEPTH (NUM_PAGES)
    ) u_kind_ram (
        .i_clk   (i_clk),
        .i_we    (kind_we),
        .i_waddr (kind_waddr),
        .i_wdata (kind_wdata),
        .i_raddr (n_idx),
        .o_rdata (kind_rdata)
    );

    // Next-page links of the free list.
    pfa_ram #(
        .WIDTH (IW),
        .DEPTH (NUM_PAGES)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (r_tail),
        .i_wdata (r_idx),
        .i_raddr (r_head),
        .o_rdata (link_rdata)
    );

    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_result_address = r_result;
    assign o_free_count     = pfa_pkg::FCOUNT_W'(r_count);

    // The count is zero exactly when the list is empty.
    `PFA_ASSERT_IMPL(a_count_matches_list, i_clk, i_rst_n, 1'b1, r_nonempty == (r_count != '0))
    // A pop never hits an empty list.
    `PFA_ASSERT_IMPL(a_pop_nonempty, i_clk, i_rst_n, i_cmd.pop, r_nonempty)
    // An append never grows the list past the number of pages.
    `PFA_ASSERT_IMPL(a_append_room, i_clk, i_rst_n, do_append, r_count < CW'(NUM_PAGES))
    // Each item gives a single result strobe.
    `PFA_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, r_done, !r_done)

endmodule

`default_nettype wire
